// ===== hw/rtl/mstw_pkg.sv =====
// Shared types and constants for the minimum spanning tree weight engine.
package mstw_pkg;

  // Field widths of one edge request and one result, and of the configuration word.
  localparam int unsigned NodeW   = 10;
  localparam int unsigned WeightW = 32;
  localparam int unsigned TotalW  = 48;
  localparam int unsigned CountW  = 10;
  localparam int unsigned CfgW    = 11;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_LOAD,
    ST_INIT,
    ST_SORT_START,
    ST_SIFT_RD,
    ST_SIFT_WAIT,
    ST_SIFT_CMP,
    ST_SIFT_SWAP,
    ST_EXTRACT_RD,
    ST_EXTRACT_WAIT,
    ST_EXTRACT_SWAP,
    ST_WALK_RD,
    ST_WALK_WAIT,
    ST_FIND_RD,
    ST_FIND_WAIT,
    ST_FIND_STEP,
    ST_COMP_RD,
    ST_COMP_WAIT,
    ST_COMP_STEP,
    ST_LINK_RD,
    ST_LINK_WAIT,
    ST_LINK_WR,
    ST_RESULT
  } mstw_state_t;

endpackage

// ===== hw/rtl/mstw_if.sv =====
// Valid/ready channel interface carrying one request payload.
interface mstw_if #(
  parameter int unsigned DataW = 8
);
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/minimum_spanning_tree_weight.sv =====
// Top level of the Kruskal minimum spanning tree weight engine.
// Edges load at one per cycle while the engine is in its load state. After
// the last edge, the engine clears all MAX_NODES entries of the union-find
// table, heap-sorts the edges and walks them with path-compressing finds; it
// then presents one result and takes no edge until that result is taken.
// Reset (synchronous, rst_n low) empties the store.
module minimum_spanning_tree_weight
  import mstw_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CfgW-1:0]     cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NodeW-1:0]    in_node_a,
  input  logic [NodeW-1:0]    in_node_b,
  input  logic [WeightW-1:0]  in_edge_weight,
  input  logic                in_last_edge,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TotalW-1:0]   out_total_weight,
  output logic [CountW-1:0]   out_edges_taken,
  output logic                out_overflow
);
  localparam int unsigned EAW  = $clog2(MAX_EDGES);
  localparam int unsigned ECW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned NAW  = $clog2(MAX_NODES);
  localparam int unsigned NCW  = $clog2(MAX_NODES + 1);
  localparam int unsigned EW   = 2 * NodeW + WeightW;
  localparam int unsigned RW   = 8;
  localparam int unsigned SW   = NAW + RW;

  // Channels.
  mstw_if #(.DataW(EW + 1)) in_ch ();
  mstw_if #(.DataW(TotalW + CountW + 1)) out_ch ();
  assign in_ch.valid = in_valid;
  assign in_ch.data  = {in_last_edge, in_node_a, in_node_b, in_edge_weight};
  assign in_ready    = in_ch.ready;
  assign out_valid   = out_ch.valid;
  assign out_ch.ready = out_ready;
  assign {out_total_weight, out_edges_taken, out_overflow} = out_ch.data;

  mstw_state_t state_r, state_nxt;
  logic [CfgW-1:0] node_count_r;
  logic [ECW-1:0]  fill_r, fill_nxt;
  logic            drop_r, drop_nxt;
  logic [NCW-1:0]  nodes_r, nodes_nxt;
  logic [NAW-1:0]  clr_r, clr_nxt;
  // Heap sort registers.
  logic [ECW-1:0]  root_r, root_nxt, len_r, len_nxt, bi_r, bi_nxt;
  logic [ECW-1:0]  child_r, child_nxt;
  logic [1:0]      rd_ph_r, rd_ph_nxt;
  logic [EW-1:0]   e_root_r, e_root_nxt, e_c1_r, e_c1_nxt, e_c2_r, e_c2_nxt;
  logic            build_r, build_nxt, sw_ph_r, sw_ph_nxt;
  // Walk registers.
  logic [ECW-1:0]  wi_r, wi_nxt;
  logic [EW-1:0]   we_r, we_nxt;
  logic [NAW-1:0]  x_r, x_nxt, rt_r, rt_nxt, ra_r, ra_nxt;
  logic            side_r, side_nxt;
  logic [RW-1:0]   rka_r, rka_nxt;
  logic [TotalW-1:0] total_r, total_nxt;
  logic [CountW-1:0] taken_r, taken_nxt;
  logic            ovf_r, ovf_nxt;

  // Edge store and union-find memories.
  logic           e_we;
  logic [EAW-1:0] e_wa, e_ra;
  logic [EW-1:0]  e_wd, e_rd;
  logic           s_we;
  logic [NAW-1:0] s_wa, s_ra;
  logic [SW-1:0]  s_wd, s_rd;
  logic [NAW-1:0] s_par;
  logic [RW-1:0]  s_rank;
  assign s_par  = s_rd[SW-1:RW];
  assign s_rank = s_rd[RW-1:0];

  mstw_ram #(.Width(EW), .Depth(MAX_EDGES)) u_edges (
    .clk, .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd), .rd_addr(e_ra), .rd_data(e_rd)
  );
  mstw_ram #(.Width(SW), .Depth(MAX_NODES)) u_sets (
    .clk, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd), .rd_addr(s_ra), .rd_data(s_rd)
  );

  function automatic logic [WeightW-1:0] key_of(input logic [EW-1:0] e);
    return e[WeightW-1:0] ^ {1'b1, {(WeightW-1){1'b0}}};
  endfunction

  logic [NodeW-1:0] we_a, we_b;
  assign we_a = we_r[EW-1 -: NodeW];
  assign we_b = we_r[WeightW +: NodeW];

  logic [ECW:0] c1_w;
  assign c1_w = {root_r, 1'b1};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CfgW'(1024);
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r  <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    nodes_r <= nodes_nxt; clr_r <= clr_nxt; root_r <= root_nxt; len_r <= len_nxt;
    bi_r <= bi_nxt; child_r <= child_nxt; rd_ph_r <= rd_ph_nxt; e_root_r <= e_root_nxt;
    e_c1_r <= e_c1_nxt; e_c2_r <= e_c2_nxt; build_r <= build_nxt; sw_ph_r <= sw_ph_nxt;
    wi_r <= wi_nxt; we_r <= we_nxt; x_r <= x_nxt; rt_r <= rt_nxt; ra_r <= ra_nxt;
    side_r <= side_nxt; rka_r <= rka_nxt; total_r <= total_nxt; taken_r <= taken_nxt;
    ovf_r <= ovf_nxt;
  end

  assign in_ch.ready  = (state_r == ST_LOAD);
  assign out_ch.valid = (state_r == ST_RESULT);
  assign out_ch.data  = {total_r, taken_r, ovf_r};

  // Sequencer: load, clear, heap sort, union-find walk, result.
  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; drop_nxt = drop_r; nodes_nxt = nodes_r;
    clr_nxt = clr_r; root_nxt = root_r; len_nxt = len_r; bi_nxt = bi_r;
    child_nxt = child_r; rd_ph_nxt = rd_ph_r; e_root_nxt = e_root_r; e_c1_nxt = e_c1_r;
    e_c2_nxt = e_c2_r; build_nxt = build_r; sw_ph_nxt = sw_ph_r; wi_nxt = wi_r;
    we_nxt = we_r; x_nxt = x_r; rt_nxt = rt_r; ra_nxt = ra_r; side_nxt = side_r;
    rka_nxt = rka_r; total_nxt = total_r; taken_nxt = taken_r; ovf_nxt = ovf_r;
    e_we = 1'b0; e_wa = '0; e_wd = in_ch.data[EW-1:0]; e_ra = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
    case (state_r)
      ST_LOAD: begin
        e_wa = fill_r[EAW-1:0];
        if (in_ch.valid) begin
          if (fill_r < ECW'(MAX_EDGES)) begin
            e_we = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_ch.data[EW]) begin
            if (node_count_r == '0) nodes_nxt = NCW'(1);
            else if (node_count_r > CfgW'(MAX_NODES)) nodes_nxt = NCW'(MAX_NODES);
            else nodes_nxt = NCW'(node_count_r);
            clr_nxt = '0;
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        s_we = 1'b1; s_wa = clr_r; s_wd = {clr_r, {RW{1'b0}}};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == NAW'(MAX_NODES - 1)) begin
          state_nxt = ST_SORT_START;
        end
        ovf_nxt = drop_r; total_nxt = '0; taken_nxt = '0;
        len_nxt = fill_r; bi_nxt = fill_r >> 1; build_nxt = 1'b1;
      end
      ST_SORT_START: begin
        // Build phase walks roots down from len/2-1; extract phase follows.
        if (build_r && bi_r != '0) begin
          root_nxt = bi_r - 1'b1; bi_nxt = bi_r - 1'b1;
          rd_ph_nxt = '0; state_nxt = ST_SIFT_RD;
        end else begin
          build_nxt = 1'b0;
          if (build_r) bi_nxt = fill_r;
          if ((build_r ? fill_r : bi_r) <= ECW'(1)) begin
            wi_nxt = '0; state_nxt = ST_WALK_RD;
          end else begin
            bi_nxt = (build_r ? fill_r : bi_r) - 1'b1;
            state_nxt = ST_EXTRACT_RD;
          end
        end
      end
      ST_EXTRACT_RD: begin
        // Swap entry 0 with entry bi, then sift from 0 over length bi.
        e_ra = '0; rd_ph_nxt = '0; state_nxt = ST_EXTRACT_WAIT;
      end
      ST_EXTRACT_WAIT: begin
        e_ra = bi_r[EAW-1:0];
        if (rd_ph_r == 2'd0) begin
          e_root_nxt = e_rd; rd_ph_nxt = 2'd1;
        end else begin
          e_c1_nxt = e_rd; sw_ph_nxt = 1'b0; state_nxt = ST_EXTRACT_SWAP;
        end
      end
      ST_EXTRACT_SWAP: begin
        e_we = 1'b1;
        if (!sw_ph_r) begin
          e_wa = '0; e_wd = e_c1_r; sw_ph_nxt = 1'b1;
        end else begin
          e_wa = bi_r[EAW-1:0]; e_wd = e_root_r;
          root_nxt = '0; len_nxt = bi_r; rd_ph_nxt = '0; state_nxt = ST_SIFT_RD;
        end
      end
      ST_SIFT_RD: begin
        // Fetch root, left and right child; stop when the root has no left child.
        if (c1_w >= {1'b0, len_r}) begin
          state_nxt = ST_SORT_START;
        end else begin
          e_ra = root_r[EAW-1:0]; rd_ph_nxt = '0; state_nxt = ST_SIFT_WAIT;
        end
      end
      ST_SIFT_WAIT: begin
        rd_ph_nxt = rd_ph_r + 1'b1;
        case (rd_ph_r)
          2'd0: begin
            e_ra = c1_w[EAW-1:0]; e_root_nxt = e_rd;
          end
          2'd1: begin
            e_ra = EAW'(c1_w + 1'b1); e_c1_nxt = e_rd;
          end
          default: begin
            e_c2_nxt = e_rd; state_nxt = ST_SIFT_CMP;
          end
        endcase
      end
      ST_SIFT_CMP: begin
        if ((c1_w + 1'b1) < {1'b0, len_r} && key_of(e_c2_r) > key_of(e_c1_r)) begin
          child_nxt = ECW'(c1_w + 1'b1); e_c1_nxt = e_c2_r;
        end else begin
          child_nxt = ECW'(c1_w);
        end
        if (((c1_w + 1'b1) < {1'b0, len_r} && key_of(e_c2_r) > key_of(e_c1_r))
            ? key_of(e_c2_r) <= key_of(e_root_r) : key_of(e_c1_r) <= key_of(e_root_r)) begin
          state_nxt = ST_SORT_START;
        end else begin
          sw_ph_nxt = 1'b0; state_nxt = ST_SIFT_SWAP;
        end
      end
      ST_SIFT_SWAP: begin
        e_we = 1'b1;
        if (!sw_ph_r) begin
          e_wa = root_r[EAW-1:0]; e_wd = e_c1_r; sw_ph_nxt = 1'b1;
        end else begin
          e_wa = child_r[EAW-1:0]; e_wd = e_root_r;
          root_nxt = child_r; state_nxt = ST_SIFT_RD;
        end
      end
      ST_WALK_RD: begin
        if (wi_r >= fill_r) begin
          state_nxt = ST_RESULT;
        end else begin
          e_ra = wi_r[EAW-1:0]; rd_ph_nxt = '0; state_nxt = ST_WALK_WAIT;
        end
      end
      ST_WALK_WAIT: begin
        e_ra = wi_r[EAW-1:0];
        if (rd_ph_r == '0) begin
          rd_ph_nxt = 2'd1;
        end else begin
          we_nxt = e_rd;
          wi_nxt = wi_r + 1'b1;
          if (NCW'(e_rd[EW-1 -: NodeW]) >= nodes_r || NCW'(e_rd[WeightW +: NodeW]) >= nodes_r) begin
            state_nxt = ST_WALK_RD;
          end else begin
            side_nxt = 1'b0; x_nxt = NAW'(e_rd[EW-1 -: NodeW]); rt_nxt = NAW'(e_rd[EW-1 -: NodeW]);
            state_nxt = ST_FIND_RD;
          end
        end
      end
      ST_FIND_RD: begin
        s_ra = rt_r; state_nxt = ST_FIND_WAIT;
      end
      ST_FIND_WAIT: begin
        s_ra = rt_r; state_nxt = ST_FIND_STEP;
      end
      ST_FIND_STEP: begin
        // Climb to the root, then compress the path.
        s_ra = rt_r;
        if (s_par == rt_r) state_nxt = ST_COMP_RD;
        else begin
          rt_nxt = s_par; state_nxt = ST_FIND_RD;
        end
      end
      ST_COMP_RD: begin
        s_ra = x_r; state_nxt = ST_COMP_WAIT;
      end
      ST_COMP_WAIT: begin
        s_ra = x_r; state_nxt = ST_COMP_STEP;
      end
      ST_COMP_STEP: begin
        s_ra = x_r;
        if (s_par != rt_r) begin
          s_we = 1'b1; s_wa = x_r; s_wd = {rt_r, s_rank};
          x_nxt = s_par; state_nxt = ST_COMP_RD;
        end else if (!side_r) begin
          ra_nxt = rt_r; side_nxt = 1'b1;
          x_nxt = NAW'(we_b); rt_nxt = NAW'(we_b); state_nxt = ST_FIND_RD;
        end else if (rt_r == ra_r) begin
          state_nxt = ST_WALK_RD;
        end else begin
          total_nxt = total_r + TotalW'(signed'(we_r[WeightW-1:0]));
          taken_nxt = taken_r + 1'b1;
          state_nxt = ST_LINK_RD;
        end
      end
      ST_LINK_RD: begin
        s_ra = ra_r; rd_ph_nxt = '0; state_nxt = ST_LINK_WAIT;
      end
      ST_LINK_WAIT: begin
        // The first root's rank arrives first, then the second root's entry.
        s_ra = rt_r;
        if (rd_ph_r == '0) begin
          rka_nxt = s_rank; rd_ph_nxt = 2'd1;
        end else begin
          state_nxt = ST_LINK_WR;
        end
      end
      ST_LINK_WR: begin
        // rt_r holds the second root; s_rd its entry.
        s_ra = rt_r; s_we = 1'b1;
        if (rka_r >= s_rank) begin
          if (rka_r == s_rank && rka_r != {RW{1'b1}} && !rd_ph_r[1]) begin
            s_wa = ra_r; s_wd = {ra_r, rka_r + 1'b1}; rd_ph_nxt = 2'd2;
          end else begin
            s_wa = rt_r; s_wd = {ra_r, s_rank}; state_nxt = ST_WALK_RD;
          end
        end else begin
          s_wa = ra_r; s_wd = {rt_r, rka_r}; state_nxt = ST_WALK_RD;
        end
      end
      ST_RESULT: begin
        if (out_ch.ready) begin
          fill_nxt = '0; drop_nxt = 1'b0; state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule

// ===== hw/rtl/mstw_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module mstw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the Kruskal minimum spanning tree weight engine.
`timescale 1ns / 100ps

module tb_top
  import mstw_pkg::*;
();

  localparam int unsigned NODES_MAX  = 1024;
  localparam int unsigned EDGES_MAX  = 4096;
  localparam int unsigned IDLE_LIMIT = 2000000;
  localparam int unsigned RAND_ITEMS = 650;
  localparam int unsigned REQ_W      = 2 * NodeW + WeightW + 1;
  localparam int unsigned RES_W      = TotalW + CountW + 1;

  typedef struct packed {
    logic [TotalW-1:0] total;
    logic [CountW-1:0] taken;
    logic              ovf;
  } tree_result_t;

  typedef struct {
    logic [NodeW-1:0]   a;
    logic [NodeW-1:0]   b;
    logic [WeightW-1:0] w;
    logic               last;
    bit                 typed;
    tree_result_t       res;
  } edge_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CfgW-1:0] cfg_wr_data;
  logic [TotalW-1:0] res_total;
  logic [CountW-1:0] res_taken;
  logic res_ovf;

  mstw_if #(.DataW(REQ_W)) req_ch ();
  mstw_if #(.DataW(RES_W)) res_ch ();

  assign res_ch.data = {res_total, res_taken, res_ovf};

  minimum_spanning_tree_weight u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (req_ch.valid),
    .in_ready         (req_ch.ready),
    .in_node_a        (req_ch.data[REQ_W-1 -: NodeW]),
    .in_node_b        (req_ch.data[REQ_W-1-NodeW -: NodeW]),
    .in_edge_weight   (req_ch.data[WeightW:1]),
    .in_last_edge     (req_ch.data[0]),
    .out_valid        (res_ch.valid),
    .out_ready        (res_ch.ready),
    .out_total_weight (res_total),
    .out_edges_taken  (res_taken),
    .out_overflow     (res_ovf)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Predictor state: the edges of the graph being loaded and the node count.
  int unsigned  pend_a[$];
  int unsigned  pend_b[$];
  int           pend_w[$];
  bit           pend_dropped;
  int unsigned  node_cfg;
  int unsigned  sort_ord[EDGES_MAX];
  int unsigned  sort_tmp[EDGES_MAX];
  int unsigned  uf_parent[NODES_MAX];
  tree_result_t results_due[$];
  int           mismatches;
  int           hold_tickets;
  int           hold_used;

  // Stable merge sort of edge indices by ascending signed weight.
  function automatic void sort_by_weight(int lo, int hi);
    int mid;
    int i;
    int j;
    int k;
    if (hi - lo < 1) return;
    mid = (lo + hi) / 2;
    sort_by_weight(lo, mid);
    sort_by_weight(mid + 1, hi);
    i = lo;
    j = mid + 1;
    k = lo;
    while (i <= mid || j <= hi) begin
      if (j > hi || (i <= mid && pend_w[sort_ord[i]] <= pend_w[sort_ord[j]])) begin
        sort_tmp[k] = sort_ord[i];
        i++;
      end else begin
        sort_tmp[k] = sort_ord[j];
        j++;
      end
      k++;
    end
    for (k = lo; k <= hi; k++) sort_ord[k] = sort_tmp[k];
  endfunction

  function automatic int unsigned find_set(int unsigned x);
    while (uf_parent[x] != x) begin
      uf_parent[x] = uf_parent[uf_parent[x]];
      x = uf_parent[x];
    end
    return x;
  endfunction

  // Kruskal walk over the loaded graph; clears the load afterwards.
  function automatic tree_result_t spanning_weight();
    tree_result_t r;
    int unsigned  nodes;
    int unsigned  ra;
    int unsigned  rb;
    int unsigned  e;
    longint       total;
    int unsigned  taken;
    nodes = (node_cfg == 0) ? 1 : (node_cfg > NODES_MAX) ? NODES_MAX : node_cfg;
    for (int i = 0; i < NODES_MAX; i++) uf_parent[i] = i;
    for (int i = 0; i < pend_w.size(); i++) sort_ord[i] = i;
    sort_by_weight(0, pend_w.size() - 1);
    total = 0;
    taken = 0;
    for (int i = 0; i < pend_w.size(); i++) begin
      e = sort_ord[i];
      if (pend_a[e] >= nodes || pend_b[e] >= nodes) continue;
      ra = find_set(pend_a[e]);
      rb = find_set(pend_b[e]);
      if (ra == rb) continue;
      total += longint'(pend_w[e]);
      taken++;
      uf_parent[rb] = ra;
    end
    r.total = total[TotalW-1:0];
    r.taken = taken[CountW-1:0];
    r.ovf   = pend_dropped;
    pend_a.delete();
    pend_b.delete();
    pend_w.delete();
    pend_dropped = 1'b0;
    return r;
  endfunction

  // Records one accepted request and queues the expected result on a last edge.
  function automatic void note_edge(edge_row_t row);
    tree_result_t r;
    if (pend_w.size() < EDGES_MAX) begin
      pend_a = {pend_a, int'(row.a)};
      pend_b = {pend_b, int'(row.b)};
      pend_w = {pend_w, int'(row.w)};
    end else begin
      pend_dropped = 1'b1;
    end
    if (row.last) begin
      r = spanning_weight();
      results_due = {results_due, (row.typed ? row.res : r)};
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one request and waits for it to be accepted.
  task automatic send_edge(edge_row_t row, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= {row.a, row.b, row.w, row.last};
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    note_edge(row);
  endtask

  function automatic logic [WeightW-1:0] pick_weight();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return WeightW'($signed($urandom_range(0, 20)) - 10);
    if (p < 80) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Sends a random graph with the given number of edges; most endpoints lie within the node count.
  task automatic send_graph(int unsigned n, int unsigned eff, bit no_gap);
    edge_row_t row;
    for (int unsigned i = 0; i < n; i++) begin
      row.typed = 1'b0;
      row.res   = '0;
      row.a = ($urandom_range(0, 99) < 80) ? NodeW'($urandom_range(0, eff - 1))
                                           : NodeW'($urandom_range(0, NODES_MAX - 1));
      row.b = ($urandom_range(0, 99) < 80) ? NodeW'($urandom_range(0, eff - 1))
                                           : NodeW'($urandom_range(0, NODES_MAX - 1));
      row.w    = pick_weight();
      row.last = (i == n - 1);
      send_edge(row, no_gap);
    end
  endtask

  // Holds the sender until every result is in, then lets the engine settle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_node_count(logic [CfgW-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    node_cfg = value;
  endtask

  // Result side: random stalls, calm stretches and requested long hold-offs.
  int unsigned rx_stall;
  int unsigned rx_hold;
  int unsigned rx_calm;
  tree_result_t rx_got;
  tree_result_t rx_exp;

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      rx_stall = 0;
      rx_hold  = 0;
      rx_calm  = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        rx_got = res_ch.data;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: %h", rx_got);
        end else begin
          rx_exp = results_due.pop_front();
          if (rx_got !== rx_exp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result mismatch: total exp %h got %h, taken exp %0d got %0d, %s",
                       rx_exp.total, rx_got.total, rx_exp.taken, rx_got.taken,
                       $sformatf("ovf exp %b got %b", rx_exp.ovf, rx_got.ovf));
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        res_ch.ready <= 1'b0;
      end else if (hold_tickets > hold_used) begin
        hold_used++;
        rx_hold = 3000;
        res_ch.ready <= 1'b0;
      end else if (rx_calm > 0) begin
        rx_calm--;
        res_ch.ready <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:59]:  res_ch.ready <= 1'b1;
          [60:64]: rx_calm = $urandom_range(100, 400);
          [65:94]: rx_stall = $urandom_range(1, 3);
          default: rx_stall = $urandom_range(20, 80);
        endcase
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request or a result.
  int unsigned idle_cycles;

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed requests: reset default, extreme weights and ids, self loop, ties.
  edge_row_t directed[] = '{
    '{10'd0,    10'd1,    32'd5,         1'b1, 1'b1, '{48'd5, 10'd1, 1'b0}},
    '{10'd1023, 10'd0,    32'h8000_0000, 1'b1, 1'b1, '{48'hFFFF_8000_0000, 10'd1, 1'b0}},
    '{10'd1022, 10'd1023, 32'h7FFF_FFFF, 1'b1, 1'b1, '{48'h0000_7FFF_FFFF, 10'd1, 1'b0}},
    '{10'd7,    10'd7,    32'd100,       1'b1, 1'b1, '{48'd0, 10'd0, 1'b0}},
    '{10'd0,    10'd1,    32'd3,         1'b0, 1'b0, '{48'd0, 10'd0, 1'b0}},
    '{10'd1,    10'd2,    32'd1,         1'b0, 1'b0, '{48'd0, 10'd0, 1'b0}},
    '{10'd0,    10'd2,    32'd2,         1'b0, 1'b0, '{48'd0, 10'd0, 1'b0}},
    '{10'd2,    10'd3,    32'hFFFF_FFFC, 1'b1, 1'b0, '{48'd0, 10'd0, 1'b0}},
    '{10'd4,    10'd5,    32'd7,         1'b0, 1'b0, '{48'd0, 10'd0, 1'b0}},
    '{10'd5,    10'd6,    32'd7,         1'b0, 1'b0, '{48'd0, 10'd0, 1'b0}},
    '{10'd4,    10'd6,    32'd7,         1'b1, 1'b1, '{48'd14, 10'd2, 1'b0}},
    '{10'd682,  10'd341,  32'h5555_5555, 1'b0, 1'b0, '{48'd0, 10'd0, 1'b0}},
    '{10'd341,  10'd682,  32'hAAAA_AAAA, 1'b1, 1'b0, '{48'd0, 10'd0, 1'b0}}
  };

  int unsigned phase_cfg[] = '{1024, 1, 2, 0, 2047, 16, 5, 300, 64, 3, 1024};

  initial begin
    int unsigned sent;
    int unsigned goal;
    int unsigned eff;
    int unsigned n;
    bit          calm;
    edge_row_t   row;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    mismatches   = 0;
    hold_tickets = 0;
    hold_used    = 0;
    pend_dropped = 1'b0;
    node_cfg     = NODES_MAX;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_edge(directed[i], 1'b0);
    drain();

    // Random graphs under a sequence of node counts.
    sent = 0;
    foreach (phase_cfg[p]) begin
      write_node_count(phase_cfg[p]);
      eff  = (node_cfg == 0) ? 1 : (node_cfg > NODES_MAX) ? NODES_MAX : node_cfg;
      calm = (p % 3 == 2);
      if (p == 2) hold_tickets++;
      goal = sent + RAND_ITEMS / phase_cfg.size();
      while (sent < goal) begin
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
        send_graph(n, eff, calm);
        sent += n;
      end
      drain();
    end

    // One graph that overruns the edge store.
    send_graph(EDGES_MAX + 4, NODES_MAX, 1'b1);
    drain();
    // A short graph right after the overrun must come back clean.
    row = '{10'd3, 10'd9, 32'd42, 1'b1, 1'b1, '{48'd42, 10'd1, 1'b0}};
    send_edge(row, 1'b0);
    drain();
    repeat (50) @(posedge clk);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
